// ===== rtl/core/rgb_hsv_pkg.sv =====
package rgb_hsv_pkg;

    localparam int CHAN_W  = 8;
    localparam int HUE_W   = 13;
    localparam int QUO_W   = 10;                 // hue quotient reaches 960
    localparam int REM_W   = 18;                 // 960 * 255 fits
    localparam int DEN_W   = CHAN_W + QUO_W - 1; // divisor pre-shifted by QUO_W-1
    localparam int N_CELLS = QUO_W;

    localparam logic [HUE_W-1:0] HUE_SECTOR = 13'd960;
    localparam logic [HUE_W-1:0] HUE_GREEN  = 13'd1920;
    localparam logic [HUE_W-1:0] HUE_BLUE   = 13'd3840;
    localparam logic [HUE_W-1:0] HUE_FULL   = 13'd5760;
    localparam logic [CHAN_W-1:0] SAT_SCALE = 8'd255;

    typedef enum logic [1:0] {
        SEC_RED   = 2'd0,
        SEC_GREEN = 2'd1,
        SEC_BLUE  = 2'd2
    } sector_t;

    // one long-division lane: partial remainder, shifted divisor, quotient so far
    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [DEN_W-1:0] den;
        logic [QUO_W-1:0] quo;
    } lane_t;

    typedef struct packed {
        lane_t             hue_div;
        lane_t             sat_div;
        sector_t           sector;
        logic              neg;
        logic              gray;
        logic              black;
        logic [CHAN_W-1:0] brightness;
    } stage_t;

    typedef struct packed {
        logic [HUE_W-1:0]  hue;
        logic [CHAN_W-1:0] saturation;
        logic [CHAN_W-1:0] brightness;
    } result_t;

    // one restoring step, retires one quotient bit
    function automatic lane_t div_step(lane_t l);
        logic [REM_W:0] trial;
        lane_t          o;
        trial = {1'b0, l.rem} - {{(REM_W + 1 - DEN_W){1'b0}}, l.den};
        o     = l;
        o.den = l.den >> 1;
        if (!trial[REM_W])
        begin
            o.rem = trial[REM_W-1:0];
            o.quo = {l.quo[QUO_W-2:0], 1'b1};
        end
        else
        begin
            o.quo = {l.quo[QUO_W-2:0], 1'b0};
        end
        return o;
    endfunction

    // floor correction for negative differences and wrap into one turn
    function automatic result_t finish(stage_t s);
        logic [HUE_W-1:0] base;
        logic [HUE_W-1:0] quo;
        logic [HUE_W-1:0] adj;
        result_t          r;
        case (s.sector)
            SEC_RED:   base = '0;
            SEC_GREEN: base = HUE_GREEN;
            SEC_BLUE:  base = HUE_BLUE;
            default:   base = '0;
        endcase
        quo = {{(HUE_W - QUO_W){1'b0}}, s.hue_div.quo};
        adj = quo + {{(HUE_W - 1){1'b0}}, (s.hue_div.rem != '0)};
        if (s.gray)
            r.hue = '0;
        else if (s.neg)
            r.hue = (base == '0) ? (HUE_FULL - adj) : (base - adj);
        else
            r.hue = base + quo;
        r.saturation = s.black ? '0 : s.sat_div.quo[CHAN_W-1:0];
        r.brightness = s.brightness;
        return r;
    endfunction

endpackage

// ===== rtl/core/rgb_hsv_ifs.sv =====
interface rgb_hsv_pix_if;
    logic                            valid;
    logic                            ready;
    logic [rgb_hsv_pkg::CHAN_W-1:0]  red;
    logic [rgb_hsv_pkg::CHAN_W-1:0]  green;
    logic [rgb_hsv_pkg::CHAN_W-1:0]  blue;
    modport source (output valid, red, green, blue, input ready);
    modport sink   (input valid, red, green, blue, output ready);
endinterface

interface rgb_hsv_res_if;
    logic                            valid;
    logic                            ready;
    logic [rgb_hsv_pkg::HUE_W-1:0]   hue;
    logic [rgb_hsv_pkg::CHAN_W-1:0]  saturation;
    logic [rgb_hsv_pkg::CHAN_W-1:0]  brightness;
    modport source (output valid, hue, saturation, brightness, input ready);
    modport sink   (input valid, hue, saturation, brightness, output ready);
endinterface

// ===== rtl/core/rgb_to_hsv_top.sv =====
// RGB to HSV converter for 8-bit pixels. Brightness is the largest channel,
// saturation is floor(255*delta/max) (0 for black) and hue is in sixteenths
// of a degree, 0..5759 (0 for gray). One pixel transfer is taken every clock
// while no stall holds the pipeline. Each pixel passes through the min/max and
// scaling stage, the row of division cells (one quotient bit each, hue and
// saturation side by side) and the output register. Every stage holds its item
// on a stall and frees up as soon as the next stage can take it, so bubbles
// collapse and the input keeps flowing into empty stages while a finished
// result waits at the output.
module rgb_to_hsv_top (
    input  logic         clk,
    input  logic         rst_n,
    rgb_hsv_pix_if.sink  pix,
    rgb_hsv_res_if.source res
);
    import rgb_hsv_pkg::*;

    // stage 0 is the prep register, stages 1..N_CELLS are division cells
    stage_t  st    [0:N_CELLS];
    logic    vld   [0:N_CELLS];
    logic    rdy   [0:N_CELLS+1];

    logic    res_valid_reg;
    result_t res_data_reg;
    result_t res_data_next;

    rgb_hsv_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (pix.valid),
        .red       (pix.red),
        .green     (pix.green),
        .blue      (pix.blue),
        .ready_in  (rdy[0]),
        .valid_out (vld[0]),
        .data_out  (st[0]),
        .ready_dn  (rdy[1])
    );

    // row of identical long-division cells
    for (genvar i = 1; i <= N_CELLS; i++)
    begin : g_cell
        rgb_hsv_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .valid_in  (vld[i-1]),
            .data_in   (st[i-1]),
            .ready_in  (rdy[i]),
            .valid_out (vld[i]),
            .data_out  (st[i]),
            .ready_dn  (rdy[i+1])
        );
    end

    assign pix.ready = rdy[0];

    // output register, loads whenever it is empty or being drained
    assign rdy[N_CELLS+1] = !res_valid_reg || res.ready;
    assign res_data_next  = finish(st[N_CELLS]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (rdy[N_CELLS+1])
            res_valid_reg <= vld[N_CELLS];
    end

    always_ff @(posedge clk)
    begin
        if (vld[N_CELLS] && rdy[N_CELLS+1])
            res_data_reg <= res_data_next;
    end

    assign res.valid      = res_valid_reg;
    assign res.hue        = res_data_reg.hue;
    assign res.saturation = res_data_reg.saturation;
    assign res.brightness = res_data_reg.brightness;

    // hue always lands inside one turn
    a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> (res.hue < HUE_FULL))
        else $error("hue out of range");

    // zero saturation only for gray pixels, which carry zero hue
    a_gray_hue: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && (res.saturation == '0)) |-> (res.hue == '0))
        else $error("nonzero hue with zero saturation");

    // an accepted pixel always lands in the prep stage
    a_prep_load: assert property (@(posedge clk) disable iff (!rst_n)
        (pix.valid && pix.ready) |=> vld[0])
        else $error("accepted pixel lost at prep stage");

    // a stalled output holds back the last cell
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && !res.ready && vld[N_CELLS]) |=> vld[N_CELLS])
        else $error("last cell dropped an item under stall");

endmodule

// ===== rtl/core/rgb_hsv_prep.sv =====
module rgb_hsv_prep (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           valid_in,
    input  logic [rgb_hsv_pkg::CHAN_W-1:0] red,
    input  logic [rgb_hsv_pkg::CHAN_W-1:0] green,
    input  logic [rgb_hsv_pkg::CHAN_W-1:0] blue,
    output logic                           ready_in,
    output logic                           valid_out,
    output rgb_hsv_pkg::stage_t            data_out,
    input  logic                           ready_dn
);
    import rgb_hsv_pkg::*;

    logic [CHAN_W-1:0] mx;
    logic [CHAN_W-1:0] mn;
    logic [CHAN_W-1:0] delta;
    logic [CHAN_W-1:0] op_a;
    logic [CHAN_W-1:0] op_b;
    logic [CHAN_W-1:0] mag;
    logic              valid_reg;
    stage_t            data_next;
    stage_t            data_reg;

    always_comb
    begin
        mx = red;
        if (green > mx) mx = green;
        if (blue > mx)  mx = blue;
        mn = red;
        if (green < mn) mn = green;
        if (blue < mn)  mn = blue;
        delta = mx - mn;

        data_next = '0;
        if (mx == red)
        begin
            data_next.sector = SEC_RED;
            op_a = green;
            op_b = blue;
        end
        else if (mx == green)
        begin
            data_next.sector = SEC_GREEN;
            op_a = blue;
            op_b = red;
        end
        else
        begin
            data_next.sector = SEC_BLUE;
            op_a = red;
            op_b = green;
        end
        data_next.neg = (op_a < op_b);
        mag = data_next.neg ? (op_b - op_a) : (op_a - op_b);

        data_next.hue_div.rem = {{(REM_W - CHAN_W){1'b0}}, mag} * REM_W'(HUE_SECTOR);
        data_next.hue_div.den = {delta, {(QUO_W - 1){1'b0}}};
        data_next.sat_div.rem = {{(REM_W - CHAN_W){1'b0}}, delta} * REM_W'(SAT_SCALE);
        data_next.sat_div.den = {mx, {(QUO_W - 1){1'b0}}};
        data_next.gray        = (delta == '0);
        data_next.black       = (mx == '0);
        data_next.brightness  = mx;
    end

    assign ready_in  = !valid_reg || ready_dn;
    assign valid_out = valid_reg;
    assign data_out  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (ready_in)
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        if (valid_in && ready_in)
            data_reg <= data_next;
    end

endmodule

// ===== rtl/core/rgb_hsv_cell.sv =====
module rgb_hsv_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                valid_in,
    input  rgb_hsv_pkg::stage_t data_in,
    output logic                ready_in,
    output logic                valid_out,
    output rgb_hsv_pkg::stage_t data_out,
    input  logic                ready_dn
);
    import rgb_hsv_pkg::*;

    logic   valid_reg;
    stage_t data_next;
    stage_t data_reg;

    // both dividers advance one quotient bit per cell
    always_comb
    begin
        data_next         = data_in;
        data_next.hue_div = div_step(data_in.hue_div);
        data_next.sat_div = div_step(data_in.sat_div);
    end

    assign ready_in  = !valid_reg || ready_dn;
    assign valid_out = valid_reg;
    assign data_out  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (ready_in)
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        if (valid_in && ready_in)
            data_reg <= data_next;
    end

endmodule

// ===== test/tb_rgb_to_hsv_top.sv =====
`timescale 1ns / 1ps

module tb_rgb_to_hsv_top;

    import rgb_hsv_pkg::*;

    // allow slack for the drain
    localparam int DRAIN_CYCLES  = 40;
    // cycles with no transfer on either side before the run is abandoned
    localparam int STALL_LIMIT   = 2000;
    localparam int RANDOM_PIXELS = 1900;

    // hue sector size and full turn in sixteenths of a degree
    localparam int SECTOR_UNITS = int'(HUE_SECTOR);
    localparam int TURN_UNITS   = int'(HUE_FULL);

    logic clk;
    logic rst_n;

    rgb_hsv_pix_if pix_ch ();
    rgb_hsv_res_if res_ch ();

    rgb_to_hsv_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .pix   (pix_ch),
        .res   (res_ch)
    );

    // results predicted for accepted pixels, oldest first
    result_t hsv_pending_q[$];
    int      mismatches;
    int      idle_cycles;

    // 10 ns clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // integer hsv of one pixel, floor division on the hue offset
    function automatic result_t predict_hsv(logic [CHAN_W-1:0] r, logic [CHAN_W-1:0] g,
                                            logic [CHAN_W-1:0] b);
        int      ri;
        int      gi;
        int      bi;
        int      mx;
        int      mn;
        int      delta;
        int      num;
        int      quo;
        int      base;
        int      h;
        int      s;
        sector_t sec;
        result_t o;
        ri = int'(r);
        gi = int'(g);
        bi = int'(b);
        mx = ri;
        mn = ri;
        if (gi > mx) mx = gi;
        if (bi > mx) mx = bi;
        if (gi < mn) mn = gi;
        if (bi < mn) mn = bi;
        delta = mx - mn;
        h = 0;
        s = 0;
        // red wins ties, then green
        if (mx == ri)
            sec = SEC_RED;
        else if (mx == gi)
            sec = SEC_GREEN;
        else
            sec = SEC_BLUE;
        if (delta != 0)
        begin
            case (sec)
                SEC_RED:
                begin
                    num  = SECTOR_UNITS * (gi - bi);
                    base = 0;
                end
                SEC_GREEN:
                begin
                    num  = SECTOR_UNITS * (bi - ri);
                    base = 2 * SECTOR_UNITS;
                end
                default:
                begin
                    num  = SECTOR_UNITS * (ri - gi);
                    base = 4 * SECTOR_UNITS;
                end
            endcase
            // sv division truncates, pull negative quotients down
            quo = num / delta;
            if (num < 0 && quo * delta != num)
                quo = quo - 1;
            h = quo + base;
            if (h < 0)
                h = h + TURN_UNITS;
            if (h >= TURN_UNITS)
                h = h - TURN_UNITS;
        end
        if (mx != 0)
            s = (255 * delta) / mx;
        o.hue        = h[HUE_W-1:0];
        o.saturation = s[CHAN_W-1:0];
        o.brightness = mx[CHAN_W-1:0];
        return o;
    endfunction

    // drive one pixel at the falling edge and hold it until the transfer
    task automatic send_pixel(input logic [CHAN_W-1:0] r, input logic [CHAN_W-1:0] g,
                              input logic [CHAN_W-1:0] b);
        logic taken;
        taken = 1'b0;
        @(negedge clk);
        pix_ch.valid <= 1'b1;
        pix_ch.red   <= r;
        pix_ch.green <= g;
        pix_ch.blue  <= b;
        while (!taken)
        begin
            @(posedge clk);
            taken = pix_ch.ready;
        end
        hsv_pending_q = {hsv_pending_q, predict_hsv(r, g, b)};
    endtask

    // sender gap, valid low for the given number of cycles
    task automatic hold_off(input int cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            pix_ch.valid <= 1'b0;
        end
    endtask

    // black, white, grays, the pure primaries, a dim red, a near-white and an orange
    task automatic test_extremes();
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd128, 8'd128, 8'd128);
        send_pixel(8'd1, 8'd1, 8'd1);
        send_pixel(8'd255, 8'd0, 8'd0);
        send_pixel(8'd0, 8'd255, 8'd0);
        send_pixel(8'd0, 8'd0, 8'd255);
        send_pixel(8'd1, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd254, 8'd254);
        send_pixel(8'd170, 8'd85, 8'd0);
    endtask

    // equal largest channels: red beats green and blue, green beats blue
    task automatic test_sector_ties();
        send_pixel(8'd255, 8'd255, 8'd0);
        send_pixel(8'd0, 8'd255, 8'd255);
        send_pixel(8'd255, 8'd0, 8'd255);
        send_pixel(8'd77, 8'd77, 8'd76);
    endtask

    // negative differences that floor toward minus infinity and wrap
    task automatic test_negative_hue();
        send_pixel(8'd255, 8'd0, 8'd1);
        send_pixel(8'd2, 8'd0, 8'd1);
        send_pixel(8'd0, 8'd1, 8'd2);
        send_pixel(8'd1, 8'd2, 8'd0);
        send_pixel(8'd0, 8'd2, 8'd1);
        send_pixel(8'd200, 8'd10, 8'd11);
    endtask

    // bursts of random pixels: mostly uniform, with grays, ties and edge values
    task automatic test_random_stream(input int count);
        int                burst;
        int                kind;
        logic [CHAN_W-1:0] r;
        logic [CHAN_W-1:0] g;
        logic [CHAN_W-1:0] b;
        logic [CHAN_W-1:0] v;
        while (count > 0)
        begin
            burst = $urandom_range(1, 32);
            while (burst > 0 && count > 0)
            begin
                kind = $urandom_range(0, 99);
                r = CHAN_W'($urandom_range(0, 255));
                g = CHAN_W'($urandom_range(0, 255));
                b = CHAN_W'($urandom_range(0, 255));
                v = CHAN_W'($urandom_range(0, 255));
                if (kind < 15)
                begin
                    // gray
                    r = v;
                    g = v;
                    b = v;
                end
                else if (kind < 30)
                begin
                    // two channels tie for the maximum
                    case ($urandom_range(0, 2))
                        0:
                        begin
                            r = 8'd255 - (v >> $urandom_range(0, 7));
                            g = r;
                            b = CHAN_W'(b % (r + 9'd1));
                        end
                        1:
                        begin
                            g = 8'd255 - (v >> $urandom_range(0, 7));
                            b = g;
                            r = CHAN_W'(r % (g + 9'd1));
                        end
                        default:
                        begin
                            r = 8'd255 - (v >> $urandom_range(0, 7));
                            b = r;
                            g = CHAN_W'(g % (r + 9'd1));
                        end
                    endcase
                end
                else if (kind < 42)
                begin
                    // small and rail values, tiny deltas
                    r = ($urandom_range(0, 1) != 0) ? 8'd255 : CHAN_W'($urandom_range(0, 3));
                    g = ($urandom_range(0, 1) != 0) ? 8'd255 : CHAN_W'($urandom_range(0, 3));
                    b = ($urandom_range(0, 1) != 0) ? 8'd255 : CHAN_W'($urandom_range(0, 3));
                end
                send_pixel(r, g, b);
                burst = burst - 1;
                count = count - 1;
            end
            // a third of the bursts run straight into the next one
            if ($urandom_range(0, 2) != 0)
                hold_off($urandom_range(1, 10));
        end
    endtask

    // result side stall pattern, switched to a new random mode after each span
    initial
    begin : result_stalls
        int mode;
        int span;
        int period;
        int phase;
        res_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            mode   = $urandom_range(0, 3);
            span   = $urandom_range(32, 200);
            period = $urandom_range(2, 7);
            phase  = 0;
            repeat (span)
            begin
                @(negedge clk);
                case (mode)
                    0: res_ch.ready <= 1'b1;
                    1: res_ch.ready <= ($urandom_range(0, 1) != 0);
                    2: res_ch.ready <= (phase % period) != 0;
                    default: res_ch.ready <= ($urandom_range(0, 7) == 0);
                endcase
                phase = phase + 1;
            end
        end
    end

    // compare every result transfer with the oldest prediction
    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (hsv_pending_q.size() == 0)
            begin
                $display("%0t: result with no pixel pending: hue %0d sat %0d val %0d",
                         $realtime, res_ch.hue, res_ch.saturation, res_ch.brightness);
                mismatches = mismatches + 1;
            end
            else
            begin
                want = hsv_pending_q.pop_front();
                if (res_ch.hue !== want.hue)
                begin
                    $display("%0t: hue expected %0d actual %0d",
                             $realtime, want.hue, res_ch.hue);
                    mismatches = mismatches + 1;
                end
                if (res_ch.saturation !== want.saturation)
                begin
                    $display("%0t: saturation expected %0d actual %0d",
                             $realtime, want.saturation, res_ch.saturation);
                    mismatches = mismatches + 1;
                end
                if (res_ch.brightness !== want.brightness)
                begin
                    $display("%0t: brightness expected %0d actual %0d",
                             $realtime, want.brightness, res_ch.brightness);
                    mismatches = mismatches + 1;
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin : watchdog
        if (rst_n)
        begin
            if ((pix_ch.valid && pix_ch.ready) || (res_ch.valid && res_ch.ready))
                idle_cycles <= 0;
            else if (idle_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles", $realtime, STALL_LIMIT);
                $display("tb_rgb_to_hsv_top: done, errors");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin : main_sequence
        mismatches   = 0;
        idle_cycles  = 0;
        rst_n        = 1'b0;
        pix_ch.valid = 1'b0;
        pix_ch.red   = '0;
        pix_ch.green = '0;
        pix_ch.blue  = '0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        test_extremes();
        test_sector_ties();
        test_negative_hue();
        test_random_stream(RANDOM_PIXELS);

        @(negedge clk);
        pix_ch.valid <= 1'b0;

        // drain, then watch for stray results
        while (hsv_pending_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && hsv_pending_q.size() == 0)
            $display("tb_rgb_to_hsv_top: done, clean");
        else
            $display("tb_rgb_to_hsv_top: done, errors");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/rgb_hsv_pkg.sv
rtl/core/rgb_hsv_ifs.sv
rtl/core/rgb_hsv_prep.sv
rtl/core/rgb_hsv_cell.sv
rtl/core/rgb_to_hsv_top.sv
test/tb_rgb_to_hsv_top.sv
